### rtl/core/tqm_pkg.sv
// ----------------------------------------------------------------------------
// tqm_pkg: shared types, widths and helpers of the triangle quadrature map.
// Holds the payload structs of both channels, the internal pipeline word and
// the clamp helpers that the front end and the top level both use.
// ----------------------------------------------------------------------------
`default_nettype none

package tqm_pkg;

   // Coordinate format and quadrature format.
   localparam int CW     = 32;          // coordinate width
   localparam int FB     = 16;          // coordinate fraction bits
   localparam int QW     = 17;          // quadrature value width
   localparam int QB     = 16;          // quadrature fraction bits
   localparam int JXW_W  = 64;          // jxw field width
   localparam int NLANES = 6;           // gradient components

   // Derived internal widths.
   localparam int AW      = CW + 1;           // edge vector component
   localparam int PROD_W  = 2 * AW;           // Jacobian product
   localparam int DW      = PROD_W + 1;       // signed determinant
   localparam int DMAG_W  = DW - 1;           // determinant magnitude
   localparam int NUM_W   = AW + 1;           // gradient numerator
   localparam int REM_W   = DMAG_W + 1;       // divider remainder
   localparam int QUO_W   = 2 * FB;           // divider quotient bits
   localparam int PW      = AW + QW + 1;      // edge times reference coordinate
   localparam int PSUM_W  = PW + 2;           // mapped point before the shift
   localparam int PT_W    = PSUM_W - QB;      // mapped point after the shift
   localparam int GV_W    = QUO_W + 2;        // signed gradient before clamping
   localparam int CLAMP_W = (PT_W > GV_W) ? PT_W : GV_W;
   localparam int JH      = DMAG_W / 2;       // split point of det times weight
   localparam int JP_W    = DMAG_W + QW;      // det times weight, full
   localparam int JM_W    = JP_W - QB;        // det times weight, shifted

   localparam logic [CW-1:0] COORD_MAX_C = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] COORD_MIN_C = {1'b1, {(CW-1){1'b0}}};

   typedef struct packed {
      logic signed [CW-1:0] x0;
      logic signed [CW-1:0] y0;
      logic signed [CW-1:0] x1;
      logic signed [CW-1:0] y1;
      logic signed [CW-1:0] x2;
      logic signed [CW-1:0] y2;
      logic [QW-1:0]        qp_xi;
      logic [QW-1:0]        qp_eta;
      logic [QW-1:0]        qp_weight;
   } tqm_req_type;

   typedef struct packed {
      logic signed [CW-1:0]    px;
      logic signed [CW-1:0]    py;
      logic signed [JXW_W-1:0] jxw;
      logic signed [CW-1:0]    grad0_x;
      logic signed [CW-1:0]    grad0_y;
      logic signed [CW-1:0]    grad1_x;
      logic signed [CW-1:0]    grad1_y;
      logic signed [CW-1:0]    grad2_x;
      logic signed [CW-1:0]    grad2_y;
      logic                    degenerate;
      logic                    saturated;
   } tqm_rsp_type;

   // One gradient component on its way through the divider.
   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic             neg;
      logic             ovf;
   } tqm_lane_type;

   // Word that travels down the divider chain.
   typedef struct packed {
      logic [CW-1:0]                   px;
      logic [CW-1:0]                   py;
      logic [JXW_W-1:0]                jxw;
      logic                            sat;
      logic                            degen;
      logic [DMAG_W-1:0]               dmag;
      tqm_lane_type [NLANES-1:0]       lane;
   } tqm_mid_type;

   typedef struct packed {
      logic [CW-1:0] val;
      logic          sat;
   } tqm_clamp_type;

   // Clamps a signed value to the coordinate range.
   function automatic tqm_clamp_type clamp_coord(input logic signed [CLAMP_W-1:0] v);
      tqm_clamp_type      r;
      logic [CLAMP_W-CW:0] top;
      top = v[CLAMP_W-1:CW-1];
      if ((&top) || !(|top)) begin
         r.sat = 1'b0;
         r.val = v[CW-1:0];
      end else begin
         r.sat = 1'b1;
         r.val = v[CLAMP_W-1] ? COORD_MIN_C : COORD_MAX_C;
      end
      return r;
   endfunction

   // Turns a finished divider lane into a signed, clamped gradient.
   function automatic tqm_clamp_type grad_out(input tqm_lane_type l);
      tqm_clamp_type          r;
      logic signed [GV_W-1:0] gv;
      gv = l.neg ? -$signed({2'b00, l.quo}) : $signed({2'b00, l.quo});
      if (l.ovf) begin
         r.sat = 1'b1;
         r.val = l.neg ? COORD_MIN_C : COORD_MAX_C;
      end else begin
         r = clamp_coord(CLAMP_W'(gv));
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/triangle_quadrature_map_core.sv
// ----------------------------------------------------------------------------
// triangle_quadrature_map_core: linear triangle element map for one
// quadrature point, fully pipelined.
// ----------------------------------------------------------------------------
// The request channel carries one triangle (three Q16.16 vertices) and one
// quadrature point (xi, eta, weight in unsigned Q1.16) per transaction. The
// response channel returns the mapped point, the determinant times the weight
// in Q32.32, the six shape-function gradients, and the degenerate and
// saturated flags, one response transaction per request transaction, in order.
// A request passes through seven front stages (differences, multipliers,
// determinant, magnitudes and the split det-times-weight product), one stage
// per quotient bit of the gradient divider (32 stages), and the response
// buffer register. Throughput is one transaction per cycle while the response
// buffer has room; it is set by the one-bit-per-stage divider chain, where
// every stage holds its own compare and subtract.
// A synchronous reset empties the pipeline and the response buffer; no
// request is taken during reset. When the receiver stalls, results collect in
// the two-entry response buffer; once it is full the whole pipeline holds and
// req_ready drops, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_quadrature_map_core import tqm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire tqm_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output tqm_rsp_type      rsp_data
);

   logic        en;
   logic        full;
   logic        chain_v [QUO_W+1];
   tqm_mid_type chain_d [QUO_W+1];
   tqm_mid_type last;
   tqm_rsp_type fmt;
   tqm_clamp_type g [NLANES];
   logic        gsat;

   // The pipeline moves as one piece whenever the response buffer has room.
   assign en        = !full;
   assign req_ready = en;

   tqm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (chain_v[0]),
      .out_data  (chain_d[0])
   );

   // One stage per quotient bit of the gradient division.
   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      tqm_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (chain_v[k]),
         .in_data   (chain_d[k]),
         .out_valid (chain_v[k+1]),
         .out_data  (chain_d[k+1])
      );
   end

   assign last = chain_d[QUO_W];

   // Final formatting: sign and clamp each gradient, or zero them all when
   // the triangle has no area.
   always_comb begin
      gsat = 1'b0;
      for (int i = 0; i < NLANES; i++) begin
         g[i] = grad_out(last.lane[i]);
         if (last.degen) begin
            g[i].val = '0;
         end
         gsat = gsat | g[i].sat;
      end
      fmt.px         = last.px;
      fmt.py         = last.py;
      fmt.jxw        = last.jxw;
      fmt.grad0_x    = g[0].val;
      fmt.grad0_y    = g[1].val;
      fmt.grad1_x    = g[2].val;
      fmt.grad1_y    = g[3].val;
      fmt.grad2_x    = g[4].val;
      fmt.grad2_y    = g[5].val;
      fmt.degenerate = last.degen;
      fmt.saturated  = last.sat | (gsat & !last.degen);
   end

   tqm_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (en && chain_v[QUO_W]),
      .push_data (fmt),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### rtl/core/tqm_front.sv
// ----------------------------------------------------------------------------
// tqm_front: Jacobian, mapped point and determinant-times-weight pipeline.
// Seven register stages that also prepare the six divider lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module tqm_front import tqm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        in_valid,
   input  wire tqm_req_type in_data,
   output logic             out_valid,
   output tqm_mid_type      out_data
);

   logic [6:0] v_ff;

   // Stage 1: edge vectors.
   logic signed [AW-1:0] s1_a_ff, s1_b_ff, s1_c_ff, s1_d_ff;
   logic signed [CW-1:0] s1_x0_ff, s1_y0_ff;
   logic [QW-1:0]        s1_xi_ff, s1_eta_ff, s1_w_ff;

   // Stage 2: products.
   logic signed [PROD_W-1:0] s2_ad_ff, s2_bc_ff;
   logic signed [PW-1:0]     s2_axi_ff, s2_beta_ff, s2_cxi_ff, s2_deta_ff;
   logic signed [AW-1:0]     s2_a_ff, s2_b_ff, s2_c_ff, s2_d_ff;
   logic signed [CW-1:0]     s2_x0_ff, s2_y0_ff;
   logic [QW-1:0]            s2_w_ff;

   // Stage 3: determinant, point sums, numerators.
   logic signed [DW-1:0]     s3_det_ff;
   logic signed [PSUM_W-1:0] s3_pxs_ff, s3_pys_ff;
   logic signed [NUM_W-1:0]  s3_num_ff [NLANES];
   logic [QW-1:0]            s3_w_ff;

   // Stage 4: magnitudes and finished point.
   logic [DMAG_W-1:0]        s4_dmag_ff;
   logic                     s4_dneg_ff, s4_degen_ff;
   tqm_clamp_type            s4_px_ff, s4_py_ff;
   logic [NUM_W-1:0]         s4_nmag_ff [NLANES];
   logic                     s4_nneg_ff [NLANES];
   logic [QW-1:0]            s4_w_ff;
   logic [DMAG_W-1:0]        s4_dmag_in;
   logic                     s4_dneg_in;
   tqm_clamp_type            s4_px_in, s4_py_in;

   // Stages 5 to 7: det times weight, lanes ride along.
   logic [JH+QW-1:0]         s5_jlo_ff;
   logic [DMAG_W-JH+QW-1:0]  s5_jhi_ff;
   logic                     s5_dneg_ff, s6_dneg_ff;
   logic [JM_W-1:0]          s6_jmag_ff;
   tqm_mid_type              s5_mid_ff, s6_mid_ff, s7_mid_ff;
   tqm_mid_type              s5_mid_in, s7_mid_in;

   logic signed [PSUM_W-1:0] bias;
   logic signed [PSUM_W-1:0] pxb, pyb;
   logic signed [JM_W:0]     js;
   logic [JM_W:JXW_W-1]      jtop;

   assign bias = $signed({{(PSUM_W-QB){1'b0}}, {QB{1'b1}}});

   always_comb begin
      s4_dneg_in = s3_det_ff[DW-1];
      s4_dmag_in = DMAG_W'(s4_dneg_in ? -s3_det_ff : s3_det_ff);
      // Truncate toward zero before the shift.
      pxb = s3_pxs_ff + (s3_pxs_ff[PSUM_W-1] ? bias : '0);
      pyb = s3_pys_ff + (s3_pys_ff[PSUM_W-1] ? bias : '0);
      s4_px_in = clamp_coord(CLAMP_W'(PT_W'(pxb >>> QB)));
      s4_py_in = clamp_coord(CLAMP_W'(PT_W'(pyb >>> QB)));
   end

   always_comb begin
      s5_mid_in       = '0;
      s5_mid_in.px    = s4_px_ff.val;
      s5_mid_in.py    = s4_py_ff.val;
      s5_mid_in.sat   = s4_px_ff.sat | s4_py_ff.sat;
      s5_mid_in.degen = s4_degen_ff;
      s5_mid_in.dmag  = s4_dmag_ff;
      for (int i = 0; i < NLANES; i++) begin
         s5_mid_in.lane[i].rem = REM_W'(s4_nmag_ff[i]);
         s5_mid_in.lane[i].quo = '0;
         s5_mid_in.lane[i].neg = s4_nneg_ff[i] ^ s4_dneg_ff;
         // Quotient would need more bits than the divider has: saturate.
         s5_mid_in.lane[i].ovf = REM_W'(s4_nmag_ff[i]) >= REM_W'(s4_dmag_ff);
      end
   end

   always_comb begin
      js   = s6_dneg_ff ? -$signed({1'b0, s6_jmag_ff}) : $signed({1'b0, s6_jmag_ff});
      jtop = js[JM_W:JXW_W-1];
      s7_mid_in = s6_mid_ff;
      if ((&jtop) || !(|jtop)) begin
         s7_mid_in.jxw = js[JXW_W-1:0];
      end else begin
         s7_mid_in.sat = 1'b1;
         s7_mid_in.jxw = js[JM_W] ? {1'b1, {(JXW_W-1){1'b0}}} : {1'b0, {(JXW_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_a_ff   <= AW'(in_data.x1) - AW'(in_data.x0);
         s1_b_ff   <= AW'(in_data.x2) - AW'(in_data.x0);
         s1_c_ff   <= AW'(in_data.y1) - AW'(in_data.y0);
         s1_d_ff   <= AW'(in_data.y2) - AW'(in_data.y0);
         s1_x0_ff  <= in_data.x0;
         s1_y0_ff  <= in_data.y0;
         s1_xi_ff  <= in_data.qp_xi;
         s1_eta_ff <= in_data.qp_eta;
         s1_w_ff   <= in_data.qp_weight;

         s2_ad_ff   <= s1_a_ff * s1_d_ff;
         s2_bc_ff   <= s1_b_ff * s1_c_ff;
         s2_axi_ff  <= s1_a_ff * $signed({1'b0, s1_xi_ff});
         s2_beta_ff <= s1_b_ff * $signed({1'b0, s1_eta_ff});
         s2_cxi_ff  <= s1_c_ff * $signed({1'b0, s1_xi_ff});
         s2_deta_ff <= s1_d_ff * $signed({1'b0, s1_eta_ff});
         s2_a_ff    <= s1_a_ff;
         s2_b_ff    <= s1_b_ff;
         s2_c_ff    <= s1_c_ff;
         s2_d_ff    <= s1_d_ff;
         s2_x0_ff   <= s1_x0_ff;
         s2_y0_ff   <= s1_y0_ff;
         s2_w_ff    <= s1_w_ff;

         s3_det_ff <= DW'(s2_ad_ff) - DW'(s2_bc_ff);
         s3_pxs_ff <= (PSUM_W'(s2_x0_ff) <<< QB) + PSUM_W'(s2_axi_ff) + PSUM_W'(s2_beta_ff);
         s3_pys_ff <= (PSUM_W'(s2_y0_ff) <<< QB) + PSUM_W'(s2_cxi_ff) + PSUM_W'(s2_deta_ff);
         s3_num_ff[0] <= NUM_W'(s2_c_ff) - NUM_W'(s2_d_ff);
         s3_num_ff[1] <= NUM_W'(s2_b_ff) - NUM_W'(s2_a_ff);
         s3_num_ff[2] <= NUM_W'(s2_d_ff);
         s3_num_ff[3] <= -NUM_W'(s2_b_ff);
         s3_num_ff[4] <= -NUM_W'(s2_c_ff);
         s3_num_ff[5] <= NUM_W'(s2_a_ff);
         s3_w_ff   <= s2_w_ff;

         s4_dmag_ff  <= s4_dmag_in;
         s4_dneg_ff  <= s4_dneg_in;
         s4_degen_ff <= (s3_det_ff == '0);
         s4_px_ff    <= s4_px_in;
         s4_py_ff    <= s4_py_in;
         for (int i = 0; i < NLANES; i++) begin
            s4_nneg_ff[i] <= s3_num_ff[i][NUM_W-1];
            s4_nmag_ff[i] <= NUM_W'(s3_num_ff[i][NUM_W-1] ? -s3_num_ff[i] : s3_num_ff[i]);
         end
         s4_w_ff <= s3_w_ff;

         s5_jlo_ff  <= s4_dmag_ff[JH-1:0] * s4_w_ff;
         s5_jhi_ff  <= s4_dmag_ff[DMAG_W-1:JH] * s4_w_ff;
         s5_dneg_ff <= s4_dneg_ff;
         s5_mid_ff  <= s5_mid_in;

         s6_jmag_ff <= JM_W'(((JP_W'(s5_jhi_ff) << JH) + JP_W'(s5_jlo_ff)) >> QB);
         s6_dneg_ff <= s5_dneg_ff;
         s6_mid_ff  <= s5_mid_ff;

         s7_mid_ff <= s7_mid_in;
      end
   end

   assign out_valid = v_ff[6];
   assign out_data  = s7_mid_ff;

endmodule

`default_nettype wire

### rtl/core/tqm_div_step.sv
// ----------------------------------------------------------------------------
// tqm_div_step: one restoring division step for all six gradient lanes.
// Produces one quotient bit per lane and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tqm_div_step import tqm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        in_valid,
   input  wire tqm_mid_type in_data,
   output logic             out_valid,
   output tqm_mid_type      out_data
);

   logic        v_ff;
   tqm_mid_type mid_ff;
   tqm_mid_type mid_in;
   logic [REM_W-1:0] r2 [NLANES];
   logic             ge [NLANES];

   always_comb begin
      mid_in = in_data;
      for (int i = 0; i < NLANES; i++) begin
         r2[i] = {in_data.lane[i].rem[REM_W-2:0], 1'b0};
         ge[i] = r2[i] >= REM_W'(in_data.dmag);
         mid_in.lane[i].rem = ge[i] ? r2[i] - REM_W'(in_data.dmag) : r2[i];
         mid_in.lane[i].quo = {in_data.lane[i].quo[QUO_W-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mid_ff <= mid_in;
      end
   end

   assign out_valid = v_ff;
   assign out_data  = mid_ff;

endmodule

`default_nettype wire

### rtl/core/tqm_rsp_fifo.sv
// ----------------------------------------------------------------------------
// tqm_rsp_fifo: two-entry result buffer in front of the response channel.
// Decouples the pipeline from a stalling receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module tqm_rsp_fifo import tqm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire tqm_rsp_type push_data,
   output logic             full,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output tqm_rsp_type      rsp_data
);

   tqm_rsp_type mem [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff, count_in;
   logic        pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign rsp_data  = mem[rd_ptr_ff];

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("Result buffer overflow.");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("Result buffer count out of range.");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("Result buffer count did not drop after a transaction.");

endmodule

`default_nettype wire

### sim/triangle_quadrature_map_core_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_quadrature_map_core_checker: response checker for the element map.
// Watches both channels, computes the expected response of every accepted
// request with its own wide-integer model and compares responses in order.
// ----------------------------------------------------------------------------

module triangle_quadrature_map_core_checker import tqm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire tqm_req_type req_data,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire tqm_rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count,
   output int               checked_count,
   output int               degenerate_count,
   output int               saturated_count
);

   tqm_rsp_type element_results[$];

   // Clamps a wide signed value to a signed field of the given width.
   function automatic logic [63:0] clamp_field(input logic signed [127:0] v, input int w,
                                               inout logic sat);
      logic signed [127:0] hi;
      logic signed [127:0] lo;
      hi = (128'sd1 <<< (w - 1)) - 128'sd1;
      lo = -(128'sd1 <<< (w - 1));
      if (v > hi) begin
         sat = 1'b1;
         v = hi;
      end else if (v < lo) begin
         sat = 1'b1;
         v = lo;
      end
      return v[63:0];
   endfunction

   // Exact element map; signed division truncates toward zero as required.
   function automatic tqm_rsp_type map_element(input tqm_req_type r);
      tqm_rsp_type         o;
      logic signed [127:0] a, b, c, d, det, xi, eta, wt, val;
      logic signed [127:0] num[6];
      logic [63:0]         f;
      logic                sat;
      sat = 1'b0;
      a   = 128'(r.x1) - 128'(r.x0);
      b   = 128'(r.x2) - 128'(r.x0);
      c   = 128'(r.y1) - 128'(r.y0);
      d   = 128'(r.y2) - 128'(r.y0);
      xi  = $signed({111'd0, r.qp_xi});
      eta = $signed({111'd0, r.qp_eta});
      wt  = $signed({111'd0, r.qp_weight});
      det = a * d - b * c;
      val = ((128'(r.x0) <<< QB) + a * xi + b * eta) / 128'sd65536;
      f = clamp_field(val, CW, sat);
      o.px = f[CW-1:0];
      val = ((128'(r.y0) <<< QB) + c * xi + d * eta) / 128'sd65536;
      f = clamp_field(val, CW, sat);
      o.py = f[CW-1:0];
      o.jxw = clamp_field((det * wt) / 128'sd65536, JXW_W, sat);
      o.degenerate = (det == 0);
      num[0] = c - d;
      num[1] = b - a;
      num[2] = d;
      num[3] = -b;
      num[4] = -c;
      num[5] = a;
      for (int j = 0; j < 6; j++) begin
         if (o.degenerate) begin
            f = '0;
         end else begin
            f = clamp_field((num[j] <<< (2 * FB)) / det, CW, sat);
         end
         case (j)
            0: o.grad0_x = f[CW-1:0];
            1: o.grad0_y = f[CW-1:0];
            2: o.grad1_x = f[CW-1:0];
            3: o.grad1_y = f[CW-1:0];
            4: o.grad2_x = f[CW-1:0];
            default: o.grad2_y = f[CW-1:0];
         endcase
      end
      o.saturated = sat;
      return o;
   endfunction

   function automatic void compare_field(input string name, input logic [63:0] e,
                                         input logic [63:0] g, inout string msg);
      if (e !== g) begin
         msg = {msg, $sformatf(" %s exp %h got %h;", name, e, g)};
      end
   endfunction

   always @(posedge clock) begin
      tqm_rsp_type exp_rsp;
      string       msg;
      if (reset) begin
         fail_count       <= 0;
         checked_count    <= 0;
         degenerate_count <= 0;
         saturated_count  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            element_results.push_back(map_element(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            msg = "";
            if (element_results.size() == 0) begin
               msg = " response with no request outstanding;";
            end else begin
               exp_rsp = element_results.pop_front();
               compare_field("px", exp_rsp.px, rsp_data.px, msg);
               compare_field("py", exp_rsp.py, rsp_data.py, msg);
               compare_field("jxw", exp_rsp.jxw, rsp_data.jxw, msg);
               compare_field("grad0_x", exp_rsp.grad0_x, rsp_data.grad0_x, msg);
               compare_field("grad0_y", exp_rsp.grad0_y, rsp_data.grad0_y, msg);
               compare_field("grad1_x", exp_rsp.grad1_x, rsp_data.grad1_x, msg);
               compare_field("grad1_y", exp_rsp.grad1_y, rsp_data.grad1_y, msg);
               compare_field("grad2_x", exp_rsp.grad2_x, rsp_data.grad2_x, msg);
               compare_field("grad2_y", exp_rsp.grad2_y, rsp_data.grad2_y, msg);
               compare_field("degenerate", exp_rsp.degenerate, rsp_data.degenerate, msg);
               compare_field("saturated", exp_rsp.saturated, rsp_data.saturated, msg);
               degenerate_count <= degenerate_count + exp_rsp.degenerate;
               saturated_count  <= saturated_count + exp_rsp.saturated;
            end
            checked_count <= checked_count + 1;
            if (msg != "") begin
               if (fail_count < 10) begin
                  $display("MISMATCH on response %0d:%s", checked_count, msg);
               end
               fail_count <= fail_count + 1;
            end
         end
      end
   end

   assign pending_count = element_results.size();

endmodule

### sim/triangle_quadrature_map_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_quadrature_map_core_tb: stimulus and verdict for the element map.
// Sends directed corner triangles and then random triangles and quadrature
// points with random gaps and receiver stalls; a checker instance predicts
// and compares every response.
// ----------------------------------------------------------------------------

module triangle_quadrature_map_core_tb;
   import tqm_pkg::*;

   localparam int RANDOM_ITEMS  = 530;
   localparam int WATCHDOG_MAX  = 4000;
   localparam int DRAIN_CYCLES  = 60;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   tqm_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   tqm_rsp_type rsp_data;

   int fail_count;
   int pending_count;
   int checked_count;
   int degenerate_count;
   int saturated_count;
   int sent_count;
   int idle_cycles;
   int stall_left;

   triangle_quadrature_map_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   triangle_quadrature_map_core_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count),
      .degenerate_count (degenerate_count),
      .saturated_count  (saturated_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap length shared by both sides: mostly none or short, now and then long.
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) begin
         return 0;
      end else if (pick < 90) begin
         return $urandom_range(3, 1);
      end else begin
         return $urandom_range(40, 8);
      end
   endfunction

   // The receiver stalls in random bursts; during one long stretch it never
   // stalls at all, so the pipeline also runs at full rate.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (sent_count > 200 && sent_count < 320) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready  <= 1'b1;
         stall_left <= ($urandom_range(3) == 0) ? gap_length() : 0;
      end
   end

   // The watchdog counts cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_MAX) begin
            $display("watchdog expired with %0d responses outstanding", pending_count);
            $display("triangle_quadrature_map_core verification failed");
            $finish;
         end
      end
   end

   // Presents one request and holds it until the transaction completes, then
   // optionally idles. Valid stays high when the next request follows at once.
   task automatic send_element(input tqm_req_type item, input bit allow_gap);
      int gap;
      req_valid <= 1'b1;
      req_data  <= item;
      do begin
         @(posedge clock);
      end while (!req_ready);
      sent_count <= sent_count + 1;
      gap = allow_gap ? gap_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic tqm_req_type make_element(input logic signed [31:0] x0,
         input logic signed [31:0] y0, input logic signed [31:0] x1,
         input logic signed [31:0] y1, input logic signed [31:0] x2,
         input logic signed [31:0] y2, input logic [16:0] xi, input logic [16:0] eta,
         input logic [16:0] wt);
      tqm_req_type r;
      r.x0 = x0;
      r.y0 = y0;
      r.x1 = x1;
      r.y1 = y1;
      r.x2 = x2;
      r.y2 = y2;
      r.qp_xi = xi;
      r.qp_eta = eta;
      r.qp_weight = wt;
      return r;
   endfunction

   // Small signed coordinate of up to the given number of bits.
   function automatic logic signed [31:0] small_coord(input int bits);
      logic signed [31:0] v;
      v = $urandom_range((1 << bits) - 1);
      return ($urandom_range(1) == 1) ? -v : v;
   endfunction

   function automatic logic [16:0] quad_value();
      return ($urandom_range(4) == 0) ? 17'($urandom_range(131071))
                                      : 17'($urandom_range(65536));
   endfunction

   // Random element: mostly well-shaped triangles, plus full-range noise,
   // collinear vertices and tiny triangles whose gradients blow up.
   function automatic tqm_req_type random_element();
      logic signed [31:0] x0, y0, dx, dy;
      logic [16:0]        xi, eta, wt;
      int                 kind;
      kind = $urandom_range(9);
      xi   = quad_value();
      eta  = quad_value();
      wt   = quad_value();
      x0   = small_coord(24);
      y0   = small_coord(24);
      case (kind)
         0, 1, 2, 3, 4: begin
            return make_element(x0, y0, x0 + small_coord(20), y0 + small_coord(20),
                                x0 + small_coord(20), y0 + small_coord(20), xi, eta, wt);
         end
         5, 6: begin
            return make_element($urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, 17'($urandom), 17'($urandom), 17'($urandom));
         end
         7: begin
            dx = small_coord(18);
            dy = small_coord(18);
            if ($urandom_range(1) == 1) begin
               return make_element(x0, y0, x0 + dx, y0 + dy, x0 + 2 * dx, y0 + 2 * dy,
                                   xi, eta, wt);
            end
            return make_element(x0, y0, x0 + dx, y0 + dy, x0 + dx, y0 + dy, xi, eta, wt);
         end
         default: begin
            return make_element(x0, y0, x0 + small_coord(2), y0 + small_coord(2),
                                x0 + small_coord(2), y0 + small_coord(2), xi, eta, wt);
         end
      endcase
   endfunction

   localparam logic signed [31:0] CMAX = 32'sh7fffffff;
   localparam logic signed [31:0] CMIN = 32'sh80000000;
   localparam logic signed [31:0] ONE  = 32'sh00010000;
   localparam logic [16:0]        QONE = 17'h10000;
   localparam logic [16:0]        QTOP = 17'h1ffff;

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      sent_count = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners: unit triangle, reference corners, weights at both
      // ends, point extrapolation beyond one, collinear and coincident
      // vertices, extreme coordinates that clamp the point and jxw, and tiny
      // triangles whose gradients clamp.
      send_element(make_element(0, 0, ONE, 0, 0, ONE, 0, 0, QONE), 1'b0);
      send_element(make_element(0, 0, ONE, 0, 0, ONE, QONE, 0, QONE), 1'b0);
      send_element(make_element(0, 0, ONE, 0, 0, ONE, 0, QONE, 0), 1'b0);
      send_element(make_element(0, 0, ONE, 0, 0, ONE, 17'h5555, 17'h5555, 17'h8000),
                   1'b0);
      send_element(make_element(ONE, 2 * ONE, 0, 0, 3 * ONE, -ONE, QTOP, QTOP, QTOP),
                   1'b0);
      send_element(make_element(0, 0, 0, 0, 0, 0, QONE, QONE, QONE), 1'b0);
      send_element(make_element(ONE, ONE, 2 * ONE, 2 * ONE, 3 * ONE, 3 * ONE,
                                17'h4000, 17'h4000, QONE), 1'b0);
      send_element(make_element(5, 7, 5, 7, ONE, 0, 17'h1234, 17'h4321, QONE), 1'b0);
      send_element(make_element(CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, QTOP, QTOP, QTOP),
                   1'b0);
      send_element(make_element(CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, QTOP, 0, QTOP),
                   1'b0);
      send_element(make_element(CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, 0, QTOP, QONE),
                   1'b0);
      send_element(make_element(CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, QONE, QONE, 1),
                   1'b0);
      send_element(make_element(0, 0, 1, 0, 0, 1, 1, 1, 1), 1'b0);
      send_element(make_element(0, 0, -1, 0, 0, 1, 17'h8000, 0, QONE), 1'b0);
      send_element(make_element(0, 0, 0, ONE, ONE, 0, 0, 17'h8000, QONE), 1'b0);
      send_element(make_element(CMAX, 0, CMAX - 1, 0, CMAX, 1, QONE, QONE, QONE), 1'b0);
      send_element(make_element(-ONE, -ONE, CMAX, -ONE, -ONE, 2, 17'h1, QTOP, QTOP),
                   1'b0);
      send_element(make_element(32'sh12345678, 32'shedcba987, 32'sh0f0f0f0f,
                                32'shf0f0f0f0, 32'sh55555555, 32'shaaaaaaaa,
                                17'h0aaaa, 17'h15555, 17'h1ffff), 1'b1);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // Midway, hold off until every outstanding response has arrived.
         if (i == RANDOM_ITEMS / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
         send_element(random_element(), (i < 150 || i > 300));
      end
      req_valid <= 1'b0;
      @(posedge clock);

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d element transactions and checked %0d responses,", sent_count,
               checked_count);
      $display("%0d of them degenerate and %0d with clamped outputs.", degenerate_count,
               saturated_count);
      if (fail_count == 0) begin
         $display("triangle_quadrature_map_core verification clean");
      end else begin
         $display("triangle_quadrature_map_core verification failed");
      end
      $finish;
   end

endmodule
